/* rtl/fav_pkg.sv */
// Shared types and constants of the frame averaging accumulator.
// No dependencies; imported by fav_csr_if, the top level, fav_ram and fav_div.
package fav_pkg;

   // Defaults of the top-level parameters.
   localparam int DEF_MAX_PIXELS  = 65536;
   localparam int DEF_SAMPLE_BITS = 16;
   localparam int DEF_MAX_FRAMES  = 256;

   // Headroom of a pixel sum over a sample.
   localparam int SUM_GUARD_BITS = 8;

   // Configuration register widths and reset values.
   localparam int FRAME_CFG_BITS = 9;
   localparam int PIXEL_CFG_BITS = 17;
   localparam logic [FRAME_CFG_BITS-1:0] FRAMES_RESET = 9'd1;
   localparam logic [PIXEL_CFG_BITS-1:0] PIXELS_RESET = 17'h10000;

   // Configuration port.
   localparam int CSR_INDEX_BITS = 4;
   localparam int CSR_DATA_BITS  = 32;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAMES_TO_AVERAGE = 4'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PIXELS_PER_FRAME  = 4'd1;

   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_RUN,
      DIV_FIX,
      DIV_DONE
   } fav_div_state_type;

   typedef struct packed {
      logic start;
      logic take;
   } fav_div_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } fav_div_sts_type;

   // Address width for a store of the given depth; one bit at least.
   function automatic int idx_bits(input int depth);
      return (depth > 1) ? $clog2(depth) : 1;
   endfunction

endpackage

/* rtl/fav_req_if.sv */
// Input channel of the frame averaging accumulator: one pixel sample per item.
// Depends on nothing but its width parameter.
interface fav_req_if #(
   parameter int SAMPLE_BITS = 16
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

/* rtl/fav_rsp_if.sv */
// Result channel of the frame averaging accumulator: one averaged pixel per item.
// Depends on nothing but its width parameter.
interface fav_rsp_if #(
   parameter int SAMPLE_BITS = 16
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] average;
   logic                          frame_end;

   modport source (output valid, output average, output frame_end, input ready);
   modport sink   (input valid, input average, input frame_end, output ready);
endinterface

/* rtl/fav_csr_if.sv */
// Configuration write channel of the frame averaging accumulator.
// Depends on fav_pkg for the index and data widths.
interface fav_csr_if import fav_pkg::*;;
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/frame_average_accumulator.sv */
// Frame averaging accumulator: top level, with the pixel-sum store and its
// read-modify-write path. Depends on fav_pkg, the channel interfaces, fav_ram, fav_div.
//
// Pixel samples enter on req_bus in raster order, frame after frame. Each one is
// added into its pixel's sum in a single-port-read, single-port-write memory. On
// the last frame of a group the new sum goes to a bit-serial divider, the pixel's
// sum is cleared, and the average leaves on rsp_bus with frame_end on the last
// pixel. Configuration is written on csr_bus (frames_to_average at index 0,
// pixels_per_frame at index 1), which is always ready.
// Throughput: one sample per clock on the summing frames while the divider is
// idle; the read of one sample's sum overlaps the write of the one before, with
// forwarding when both hit the same pixel. On an averaging frame a sample is held
// off until the divider, producing one quotient bit a cycle, has handed on the
// last average; a sample's average passes the read register, the divider's run,
// fix and done states and the output register. After reset the store is cleared
// one entry a cycle, all MAX_PIXELS of them, and no sample is accepted meanwhile.
// A result waits in the output register while the receiver stalls; samples keep
// being accepted until the next averaging sample is, whose average then waits in
// the divider and holds off every sample until the register frees.
module frame_average_accumulator import fav_pkg::*; #(
   parameter int MAX_PIXELS  = DEF_MAX_PIXELS,
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
   parameter int MAX_FRAMES  = DEF_MAX_FRAMES
) (
   input  logic       clock,
   input  logic       reset,
   fav_req_if.sink    req_bus,
   fav_rsp_if.source  rsp_bus,
   fav_csr_if.sink    csr_bus
);

   localparam int SUM_BITS = SAMPLE_BITS + SUM_GUARD_BITS;
   localparam int IDX_BITS = idx_bits(MAX_PIXELS);
   localparam int FI_BITS  = $clog2(MAX_FRAMES);

   // Configuration registers.
   logic [FRAME_CFG_BITS-1:0] frames_cfg_ff;
   logic [PIXEL_CFG_BITS-1:0] pixels_cfg_ff;

   // Position counters and clearing pass.
   logic [IDX_BITS-1:0] pixel_index_ff, pixel_index_in;
   logic [FI_BITS-1:0]  frame_index_ff, frame_index_in;
   logic                clearing_ff;
   logic [IDX_BITS-1:0] clr_addr_ff;

   // Sample whose stored sum is being read.
   logic                          s1_valid_ff;
   logic signed [SAMPLE_BITS-1:0] s1_sample_ff;
   logic [IDX_BITS-1:0]           s1_idx_ff;
   logic                          s1_last_pixel_ff;
   logic                          s1_last_frame_ff;

   // Write that coincided with the read now returning.
   logic                fwd_valid_ff;
   logic [IDX_BITS-1:0] fwd_addr_ff;
   logic [SUM_BITS-1:0] fwd_data_ff;

   // Output register.
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_BITS-1:0] rsp_average_ff;
   logic                   rsp_frame_end_ff;

   logic [FRAME_CFG_BITS-1:0] n_eff;
   logic [PIXEL_CFG_BITS-1:0] p_eff;
   logic                      last_pixel_now;
   logic                      last_frame_now;
   logic                      req_fire;
   logic                      div_idle;
   logic                      rsp_load;

   logic                      wr_en;
   logic [IDX_BITS-1:0]       wr_addr;
   logic [SUM_BITS-1:0]       wr_data;
   logic [SUM_BITS-1:0]       rd_data;
   logic [SUM_BITS-1:0]       base;
   logic signed [SUM_BITS:0]  sum_wide;
   logic [SUM_BITS-1:0]       sum_sat;
   logic [SUM_BITS-1:0]       sum_mag;

   fav_div_ctl_type               div_ctl;
   fav_div_sts_type               div_sts;
   logic signed [SAMPLE_BITS-1:0] div_average;
   logic                          div_frame_end;

   // Effective counts: zero means one, anything above the maximum saturates.
   always_comb begin
      if (frames_cfg_ff == '0) begin
         n_eff = FRAME_CFG_BITS'(1);
      end else if (32'(frames_cfg_ff) > MAX_FRAMES) begin
         n_eff = FRAME_CFG_BITS'(MAX_FRAMES);
      end else begin
         n_eff = frames_cfg_ff;
      end
      if (pixels_cfg_ff == '0) begin
         p_eff = PIXEL_CFG_BITS'(1);
      end else if (32'(pixels_cfg_ff) > MAX_PIXELS) begin
         p_eff = PIXEL_CFG_BITS'(MAX_PIXELS);
      end else begin
         p_eff = pixels_cfg_ff;
      end
      // Counters left past the end by a reconfiguration count as last.
      last_pixel_now = (32'(pixel_index_ff) + 32'd1 >= 32'(p_eff));
      last_frame_now = (32'(frame_index_ff) + 32'd1 >= 32'(n_eff));
   end

   // An averaging sample needs the divider free when its sum comes back.
   assign div_idle      = !div_sts.busy && !div_sts.done;
   assign req_bus.ready = !clearing_ff && div_idle && !(s1_valid_ff && s1_last_frame_ff);
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;

   always_comb begin
      pixel_index_in = pixel_index_ff;
      frame_index_in = frame_index_ff;
      if (req_fire) begin
         if (last_pixel_now) begin
            pixel_index_in = '0;
            frame_index_in = last_frame_now ? '0 : FI_BITS'(frame_index_ff + FI_BITS'(1));
         end else begin
            pixel_index_in = IDX_BITS'(pixel_index_ff + IDX_BITS'(1));
         end
      end
   end

   // Sum of the returning read, with the previous write forwarded on a match.
   always_comb begin
      base = (fwd_valid_ff && fwd_addr_ff == s1_idx_ff) ? fwd_data_ff : rd_data;
      sum_wide = $signed({base[SUM_BITS-1], base})
               + $signed({{(SUM_BITS + 1 - SAMPLE_BITS){s1_sample_ff[SAMPLE_BITS-1]}},
                          s1_sample_ff});
      if (sum_wide[SUM_BITS] != sum_wide[SUM_BITS-1]) begin
         sum_sat = sum_wide[SUM_BITS] ? {1'b1, {(SUM_BITS-1){1'b0}}}
                                      : {1'b0, {(SUM_BITS-1){1'b1}}};
      end else begin
         sum_sat = sum_wide[SUM_BITS-1:0];
      end
      sum_mag = sum_sat[SUM_BITS-1] ? SUM_BITS'(-sum_sat) : sum_sat;
   end

   always_comb begin
      wr_en   = clearing_ff || s1_valid_ff;
      wr_addr = clearing_ff ? clr_addr_ff : s1_idx_ff;
      wr_data = (clearing_ff || s1_last_frame_ff) ? '0 : sum_sat;
   end

   fav_ram #(
      .WIDTH (SUM_BITS),
      .DEPTH (MAX_PIXELS)
   ) u_sums (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (req_fire),
      .rd_addr (pixel_index_ff),
      .rd_data (rd_data)
   );

   assign rsp_load      = div_sts.done && (!rsp_valid_ff || rsp_bus.ready);
   assign div_ctl.start = s1_valid_ff && s1_last_frame_ff;
   assign div_ctl.take  = rsp_load;

   fav_div #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_div (
      .clock        (clock),
      .reset        (reset),
      .ctl          (div_ctl),
      .sts          (div_sts),
      .magnitude    (sum_mag),
      .negative     (sum_sat[SUM_BITS-1]),
      .frame_end_in (s1_last_pixel_ff),
      .divisor      (n_eff),
      .average      (div_average),
      .frame_end    (div_frame_end)
   );

   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frames_cfg_ff  <= FRAMES_RESET;
         pixels_cfg_ff  <= PIXELS_RESET;
         pixel_index_ff <= '0;
         frame_index_ff <= '0;
         clearing_ff    <= 1'b1;
         clr_addr_ff    <= '0;
         s1_valid_ff    <= 1'b0;
         fwd_valid_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_bus.valid) begin
            unique case (csr_bus.index)
               CSR_FRAMES_TO_AVERAGE: begin
                  frames_cfg_ff <= csr_bus.data[FRAME_CFG_BITS-1:0];
               end
               CSR_PIXELS_PER_FRAME: begin
                  pixels_cfg_ff <= csr_bus.data[PIXEL_CFG_BITS-1:0];
               end
               default: begin
               end
            endcase
         end
         if (clearing_ff) begin
            clr_addr_ff <= IDX_BITS'(clr_addr_ff + IDX_BITS'(1));
            if (32'(clr_addr_ff) == MAX_PIXELS - 1) begin
               clearing_ff <= 1'b0;
            end
         end
         pixel_index_ff <= pixel_index_in;
         frame_index_ff <= frame_index_in;
         s1_valid_ff    <= req_fire;
         fwd_valid_ff   <= s1_valid_ff;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_sample_ff     <= req_bus.sample;
         s1_idx_ff        <= pixel_index_ff;
         s1_last_pixel_ff <= last_pixel_now;
         s1_last_frame_ff <= last_frame_now;
      end
      fwd_addr_ff <= s1_idx_ff;
      fwd_data_ff <= wr_data;
      if (rsp_load) begin
         rsp_average_ff   <= div_average;
         rsp_frame_end_ff <= div_frame_end;
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.average   = rsp_average_ff;
   assign rsp_bus.frame_end = rsp_frame_end_ff;

   // An averaging sum never arrives while the divider is occupied.
   a_div_free: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_last_frame_ff) |-> div_idle)
      else $error("averaging sum arrived while the divider was occupied");

   // No item is taken while the store is being cleared.
   a_no_accept_clearing: assert property (@(posedge clock) disable iff (reset)
      clearing_ff |-> !req_fire)
      else $error("item accepted during the clearing pass");

   // A new average never overwrites one still waiting to be taken.
   a_rsp_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_bus.ready) |-> !rsp_load)
      else $error("pending result overwritten");

   // The last pixel of a frame brings the pixel counter back to the start.
   a_pixel_wrap: assert property (@(posedge clock) disable iff (reset)
      (req_fire && last_pixel_now) |=> (pixel_index_ff == '0))
      else $error("pixel counter did not wrap at the end of a frame");

endmodule

/* rtl/fav_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// A read of the address written at the same edge returns the old contents.
module fav_ram import fav_pkg::*; #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 65536
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [idx_bits(DEPTH)-1:0]  wr_addr,
   input  logic [WIDTH-1:0]            wr_data,
   input  logic                        rd_en,
   input  logic [idx_bits(DEPTH)-1:0]  rd_addr,
   output logic [WIDTH-1:0]            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/fav_div.sv */
// Bit-serial restoring divider: magnitude of a pixel sum over the frame count,
// one quotient bit a cycle, then sign and saturation. Depends on fav_pkg.
module fav_div import fav_pkg::*; #(
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  fav_div_ctl_type                        ctl,
   output fav_div_sts_type                        sts,
   input  logic [SAMPLE_BITS+SUM_GUARD_BITS-1:0]  magnitude,
   input  logic                                   negative,
   input  logic                                   frame_end_in,
   input  logic [FRAME_CFG_BITS-1:0]              divisor,
   output logic signed [SAMPLE_BITS-1:0]          average,
   output logic                                   frame_end
);

   localparam int SUM_BITS = SAMPLE_BITS + SUM_GUARD_BITS;
   localparam int CNT_BITS = $clog2(SUM_BITS);
   localparam logic [SUM_BITS-1:0] POS_LIMIT =
      SUM_BITS'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
   localparam logic [SUM_BITS-1:0] NEG_LIMIT = POS_LIMIT + SUM_BITS'(1);
   localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = SAMPLE_BITS'(POS_LIMIT);
   localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = ~SAMPLE_MAX;

   fav_div_state_type state_ff, state_in;

   logic [CNT_BITS-1:0]       count_ff;
   logic [SUM_BITS-1:0]       dvd_ff;
   logic [FRAME_CFG_BITS-1:0] rem_ff;
   logic [FRAME_CFG_BITS-1:0] dsr_ff;
   logic                      neg_ff;
   logic                      end_ff;
   logic [SAMPLE_BITS-1:0]    avg_ff;

   logic [FRAME_CFG_BITS:0]   trial;
   logic [FRAME_CFG_BITS:0]   diff;
   logic                      fits;
   logic [SAMPLE_BITS-1:0]    avg_in;
   logic [SUM_BITS-1:0]       quot_neg;

   // One restoring step: bring down the next dividend bit, subtract if it fits.
   always_comb begin
      trial = {rem_ff, dvd_ff[SUM_BITS-1]};
      diff  = trial - {1'b0, dsr_ff};
      fits  = (trial >= {1'b0, dsr_ff});
   end

   // Sign the quotient and clip it to the sample range.
   always_comb begin
      quot_neg = SUM_BITS'(-dvd_ff);
      if (neg_ff) begin
         avg_in = (dvd_ff > NEG_LIMIT) ? SAMPLE_MIN : quot_neg[SAMPLE_BITS-1:0];
      end else begin
         avg_in = (dvd_ff > POS_LIMIT) ? SAMPLE_MAX : dvd_ff[SAMPLE_BITS-1:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         DIV_IDLE: begin
            if (ctl.start) begin
               state_in = DIV_RUN;
            end
         end
         DIV_RUN: begin
            if (count_ff == CNT_BITS'(SUM_BITS - 1)) begin
               state_in = DIV_FIX;
            end
         end
         DIV_FIX: begin
            state_in = DIV_DONE;
         end
         DIV_DONE: begin
            if (ctl.take) begin
               state_in = DIV_IDLE;
            end
         end
         default: begin
            state_in = DIV_IDLE;
         end
      endcase
   end

   always_comb begin
      sts.busy = (state_ff == DIV_RUN) || (state_ff == DIV_FIX);
      sts.done = (state_ff == DIV_DONE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DIV_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == DIV_IDLE && ctl.start) begin
         dvd_ff   <= magnitude;
         rem_ff   <= '0;
         dsr_ff   <= divisor;
         neg_ff   <= negative;
         end_ff   <= frame_end_in;
         count_ff <= '0;
      end else if (state_ff == DIV_RUN) begin
         dvd_ff   <= {dvd_ff[SUM_BITS-2:0], fits};
         rem_ff   <= fits ? diff[FRAME_CFG_BITS-1:0] : trial[FRAME_CFG_BITS-1:0];
         count_ff <= count_ff + CNT_BITS'(1);
      end
      if (state_ff == DIV_FIX) begin
         avg_ff <= avg_in;
      end
   end

   assign average   = avg_ff;
   assign frame_end = end_ff;

endmodule
